/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules of the tilt filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/tcf_pkg.sv */
// Types, constants and the arctangent table of the tilt filter.
package tcf_pkg;

  localparam int ANGLE_ITERATIONS = 16;
  localparam int ITER_W = 5;
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ANGLE_ITERATIONS - 1);

  localparam int AW = 27;
  localparam int ZW = 26;
  localparam int EST_W = 26;
  localparam logic signed [ZW-1:0] DEG90 = ZW'(90 * 65536);

  localparam logic [16:0] DIV_K = 17'd131000;
  localparam logic [47:0] DIV_BIAS = 48'd65500;
  localparam logic [31:0] DIV_RECIP = 32'd2148663944;
  localparam logic [1:0] DIV_LAST = 2'd3;

  localparam logic [4:0] SQ_STEPS = 5'd24;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic [15:0] elapsed_ms;
    logic roll_zero;
    logic pitch_zero;
  } tcf_item_t;

  typedef struct packed {
    logic valid;
    tcf_item_t item;
  } tcf_qword_t;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [ITER_W-1:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0: v = 22'd2949120;
      5'd1: v = 22'd1740967;
      5'd2: v = 22'd919879;
      5'd3: v = 22'd466945;
      5'd4: v = 22'd234379;
      5'd5: v = 22'd117304;
      5'd6: v = 22'd58666;
      5'd7: v = 22'd29335;
      5'd8: v = 22'd14668;
      5'd9: v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return ZW'(v);
  endfunction

endpackage

/* hw/rtl/tcf_queue.sv */
// Front end: accepts input words, flags zero vectors and queues them for the engine.
`include "assert_macros.svh"

module tcf_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  accel_x,
  input  logic signed [15:0]  accel_y,
  input  logic signed [15:0]  accel_z,
  input  logic signed [15:0]  gyro_x,
  input  logic signed [15:0]  gyro_y,
  input  logic [15:0]         elapsed_ms,
  output tcf_pkg::tcf_qword_t head,
  input  logic                pop
);
  import tcf_pkg::*;

  tcf_item_t mem [2];
  tcf_item_t entry;
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic push;
  logic take;

  always_comb begin
    entry.accel_x = accel_x;
    entry.accel_y = accel_y;
    entry.accel_z = accel_z;
    entry.gyro_x = gyro_x;
    entry.gyro_y = gyro_y;
    entry.elapsed_ms = elapsed_ms;
    entry.roll_zero = (accel_y == 16'sd0) && (accel_z == 16'sd0);
    entry.pitch_zero = entry.roll_zero && (accel_x == 16'sd0);
  end

  assign in_stall = (count == 2'd2);
  assign push = in_valid && !in_stall;
  assign take = pop && head.valid;
  assign head.valid = (count != 2'd0);
  assign head.item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (take) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(take);
    end
  end

  `ASSERT_ALWAYS(a_count_range, clk, rst, count != 2'd3, "queue count out of range")
  `ASSERT_NEXT(a_full_holds, clk, rst, (count == 2'd2) && !pop, count == 2'd2, "full queue lost a word")

endmodule

/* hw/rtl/tcf_cordic.sv */
// Vectoring CORDIC unit that yields atan2 in 1/65536 degree, one micro-rotation a cycle.
module tcf_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              zero,
  input  logic signed [tcf_pkg::AW-1:0]     x_in,
  input  logic signed [tcf_pkg::AW-1:0]     y_in,
  output logic                              busy,
  output logic signed [tcf_pkg::ZW-1:0]     angle
);
  import tcf_pkg::*;

  logic signed [AW-1:0] x;
  logic signed [AW-1:0] y;
  logic [ITER_W-1:0] cnt;
  logic signed [AW-1:0] dx;
  logic signed [AW-1:0] dy;

  assign dx = y >>> cnt;
  assign dy = x >>> cnt;

  always_ff @(posedge clk) begin
    if (start) begin
      if (zero) begin
        angle <= '0;
      end else if (x_in < 0) begin
        if (y_in >= 0) begin
          x <= y_in;
          y <= -x_in;
          angle <= DEG90;
        end else begin
          x <= -y_in;
          y <= x_in;
          angle <= -DEG90;
        end
      end else begin
        x <= x_in;
        y <= y_in;
        angle <= '0;
      end
    end else if (busy) begin
      if (y > 0) begin
        x <= x + dx;
        y <= y - dy;
        angle <= angle + atan_entry(cnt);
      end else begin
        x <= x - dx;
        y <= y + dy;
        angle <= angle - atan_entry(cnt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= !zero;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == ITER_LAST) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/tcf_div.sv */
// Gyro increment by reciprocal multiplication and a remainder correction.
module tcf_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               neg,
  input  logic [31:0]        mag,
  output logic               busy,
  output logic signed [31:0] inc
);
  import tcf_pkg::*;

  localparam logic [1:0] D_MUL = 2'd0;
  localparam logic [1:0] D_QUO = 2'd1;
  localparam logic [1:0] D_REM = 2'd2;
  localparam logic [1:0] D_FIX = 2'd3;

  logic [31:0] mag_q;
  logic [47:0] num;
  logic [63:0] prod;
  logic [63:0] prod_rnd;
  logic [30:0] quo;
  logic [47:0] rem;
  logic [1:0] cnt;
  logic sign;

  assign prod_rnd = prod + 64'h0000_0000_8000_0000;
  assign inc = sign ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  always_ff @(posedge clk) begin
    if (start) begin
      mag_q <= mag;
      sign <= neg;
    end else if (busy) begin
      unique case (cnt)
        D_MUL: begin
          prod <= mag_q * DIV_RECIP;
          num <= {mag_q, 16'h0000} + DIV_BIAS;
        end
        D_QUO: quo <= prod_rnd[62:32];
        D_REM: rem <= num - 48'(quo) * 48'(DIV_K);
        D_FIX: begin
          if (rem >= 48'(DIV_K)) begin
            quo <= quo + 31'd1;
          end
        end
        default: quo <= quo;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_LAST) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/tcf_engine.sv */
// Back end: square root, both angles, gyro integration and the weighted blend per word.
`include "assert_macros.svh"

module tcf_engine (
  input  logic                             clk,
  input  logic                             rst,
  input  tcf_pkg::tcf_qword_t              head,
  output logic                             pop,
  input  logic [15:0]                      weight,
  output logic                             res_valid,
  input  logic                             res_ack,
  output logic signed [15:0]               res_roll,
  output logic signed [15:0]               res_pitch
);
  import tcf_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PREP     = 4'd1;
  localparam logic [3:0] S_RUN      = 4'd2;
  localparam logic [3:0] S_PITCH_GO = 4'd3;
  localparam logic [3:0] S_PITCH    = 4'd4;
  localparam logic [3:0] S_MUL_R    = 4'd5;
  localparam logic [3:0] S_FIN_R    = 4'd6;
  localparam logic [3:0] S_MUL_P    = 4'd7;
  localparam logic [3:0] S_FIN_P    = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  localparam logic signed [35:0] EST_HI = 36'sd33554431;
  localparam logic signed [35:0] EST_LO = -36'sd33554432;

  logic [3:0] state;
  logic [3:0] state_next;
  tcf_item_t item;
  logic [30:0] sq_ay;
  logic [30:0] sq_az;
  logic signed [32:0] prod_gx;
  logic signed [32:0] prod_gy;
  logic [47:0] sq_v;
  logic [25:0] sq_rem;
  logic [23:0] sq_root;
  logic [4:0] sq_cnt;
  logic [27:0] sq_trial_rem;
  logic [27:0] sq_trial;
  logic sq_done;
  logic signed [ZW-1:0] roll_tilt;
  logic signed [EST_W-1:0] est_r;
  logic signed [EST_W-1:0] est_p;
  logic signed [50:0] prod;
  logic signed [33:0] diff;
  logic signed [50:0] mul_res;
  logic signed [50:0] rnd;
  logic signed [35:0] mix;
  logic signed [ZW-1:0] acc_sel;
  logic signed [EST_W-1:0] est_sat;

  logic cor_start;
  logic cor_zero;
  logic signed [AW-1:0] cor_x;
  logic signed [AW-1:0] cor_y;
  logic cor_busy;
  logic signed [ZW-1:0] cor_angle;
  logic div_start;
  logic div_r_busy;
  logic div_p_busy;
  logic signed [31:0] inc_r;
  logic signed [31:0] inc_p;
  logic [32:0] abs_gx;
  logic [32:0] abs_gy;

  assign pop = (state == S_IDLE) && head.valid;
  assign res_valid = (state == S_DONE);
  assign res_roll = est_r[25:10];
  assign res_pitch = est_p[25:10];

  assign div_start = (state == S_PREP);
  assign abs_gx = prod_gx[32] ? 33'(-prod_gx) : 33'(prod_gx);
  assign abs_gy = prod_gy[32] ? 33'(-prod_gy) : 33'(prod_gy);

  tcf_div u_div_r (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .neg  (prod_gx[32]),
    .mag  (abs_gx[31:0]),
    .busy (div_r_busy),
    .inc  (inc_r)
  );

  tcf_div u_div_p (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .neg  (prod_gy[32]),
    .mag  (abs_gy[31:0]),
    .busy (div_p_busy),
    .inc  (inc_p)
  );

  always_comb begin
    cor_start = (state == S_PREP) || (state == S_PITCH_GO);
    if (state == S_PITCH_GO) begin
      cor_zero = item.pitch_zero;
      cor_x = AW'({1'b0, sq_root});
      cor_y = -AW'($signed({item.accel_x, 8'h00}));
    end else begin
      cor_zero = item.roll_zero;
      cor_x = AW'($signed({item.accel_z, 8'h00}));
      cor_y = AW'($signed({item.accel_y, 8'h00}));
    end
  end

  tcf_cordic u_cordic (
    .clk  (clk),
    .rst  (rst),
    .start(cor_start),
    .zero (cor_zero),
    .x_in (cor_x),
    .y_in (cor_y),
    .busy (cor_busy),
    .angle(cor_angle)
  );

  assign sq_trial_rem = {sq_rem, sq_v[47:46]};
  assign sq_trial = {2'b00, sq_root, 2'b01};
  assign sq_done = (sq_cnt == SQ_STEPS);

  always_comb begin
    if (state == S_MUL_P || state == S_FIN_P) begin
      diff = 34'(est_p) + 34'(inc_p) - 34'(cor_angle);
      acc_sel = cor_angle;
    end else begin
      diff = 34'(est_r) + 34'(inc_r) - 34'(roll_tilt);
      acc_sel = roll_tilt;
    end
    mul_res = $signed({1'b0, weight}) * diff;
    rnd = prod + 51'sd32768;
    mix = 36'($signed(rnd[50:16])) + 36'(acc_sel);
    if (mix > EST_HI) begin
      est_sat = EST_HI[EST_W-1:0];
    end else if (mix < EST_LO) begin
      est_sat = EST_LO[EST_W-1:0];
    end else begin
      est_sat = mix[EST_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (head.valid) begin
          state_next = S_PREP;
        end
      end
      S_PREP: state_next = S_RUN;
      S_RUN: begin
        if (!cor_busy && sq_done) begin
          state_next = S_PITCH_GO;
        end
      end
      S_PITCH_GO: state_next = S_PITCH;
      S_PITCH: begin
        if (!cor_busy && !div_r_busy && !div_p_busy) begin
          state_next = S_MUL_R;
        end
      end
      S_MUL_R: state_next = S_FIN_R;
      S_FIN_R: state_next = S_MUL_P;
      S_MUL_P: state_next = S_FIN_P;
      S_FIN_P: state_next = S_DONE;
      S_DONE: begin
        if (res_ack) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      est_r <= '0;
      est_p <= '0;
      sq_cnt <= SQ_STEPS;
    end else begin
      state <= state_next;
      if (state == S_FIN_R) begin
        est_r <= est_sat;
      end
      if (state == S_FIN_P) begin
        est_p <= est_sat;
      end
      if (state == S_PREP) begin
        sq_cnt <= '0;
      end else if (!sq_done) begin
        sq_cnt <= sq_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item <= head.item;
      sq_ay <= 31'(head.item.accel_y * head.item.accel_y);
      sq_az <= 31'(head.item.accel_z * head.item.accel_z);
      prod_gx <= head.item.gyro_x * $signed({1'b0, head.item.elapsed_ms});
      prod_gy <= head.item.gyro_y * $signed({1'b0, head.item.elapsed_ms});
    end
    if (state == S_PREP) begin
      sq_v <= {32'(sq_ay) + 32'(sq_az), 16'h0000};
      sq_rem <= '0;
      sq_root <= '0;
    end else if (!sq_done) begin
      sq_v <= {sq_v[45:0], 2'b00};
      if (sq_trial_rem >= sq_trial) begin
        sq_rem <= 26'(sq_trial_rem - sq_trial);
        sq_root <= {sq_root[22:0], 1'b1};
      end else begin
        sq_rem <= sq_trial_rem[25:0];
        sq_root <= {sq_root[22:0], 1'b0};
      end
    end
    if (state == S_PITCH_GO) begin
      roll_tilt <= cor_angle;
    end
    if (state == S_MUL_R || state == S_MUL_P) begin
      prod <= mul_res;
    end
  end

  `ASSERT_ALWAYS(a_div_lockstep, clk, rst, div_r_busy == div_p_busy, "dividers out of step")
  `ASSERT_IMPLIES(a_pitch_root_ready, clk, rst, state == S_PITCH_GO, sq_done, "pitch started before root")
  `ASSERT_IMPLIES(a_result_idle, clk, rst, res_valid, !cor_busy && !div_r_busy, "result while units busy")

endmodule

/* hw/rtl/tilt_complementary_filter.sv */
// Tilt complementary filter top level: weight register, front queue, engine and output word.
// The engine takes one word at a time; the queue holds up to two further words while it works.
// The time per word is set by the 24-step square root, the pitch CORDIC pass on the shared
// unit that waits for the root, and the two blend multiplies.
// Synchronous reset clears the estimates, the queue and the output valid flag, and loads weight 62915.
module tilt_complementary_filter (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic [15:0]        elapsed_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] roll_angle,
  output logic signed [15:0] pitch_angle,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        gyro_weight
);
  import tcf_pkg::*;

  tcf_qword_t head;
  logic pop;
  logic [15:0] weight;
  logic res_valid;
  logic res_ack;
  logic signed [15:0] res_roll;
  logic signed [15:0] res_pitch;

  assign cfg_ready = 1'b1;
  assign res_ack = res_valid && (!out_valid || !out_stall);

  tcf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .accel_x   (accel_x),
    .accel_y   (accel_y),
    .accel_z   (accel_z),
    .gyro_x    (gyro_x),
    .gyro_y    (gyro_y),
    .elapsed_ms(elapsed_ms),
    .head      (head),
    .pop       (pop)
  );

  tcf_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .weight   (weight),
    .res_valid(res_valid),
    .res_ack  (res_ack),
    .res_roll (res_roll),
    .res_pitch(res_pitch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= 16'd62915;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        weight <= gyro_weight;
      end
      if (res_ack) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      roll_angle <= res_roll;
      pitch_angle <= res_pitch;
    end
  end

endmodule
